/* hw/rtl/stgu_pkg.sv */
// stgu_pkg: types, constants and the word packing function of the
// sgi target list generator; no dependencies
package stgu_pkg;

    localparam int MAX_CORES      = 8;
    localparam int DEF_CORE_COUNT = 4;
    localparam int AFF_W          = 40;
    localparam int CLUSTER_W      = 32;
    localparam int TLIST_W        = 16;
    localparam int SGI_W          = 4;
    localparam int MASK_W         = 8;
    localparam int WORD_W         = 56;
    localparam int CFG_IDX_W      = 4;

    typedef struct packed {
        logic [SGI_W-1:0]  sgi_id;
        logic [MASK_W-1:0] target_mask;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] sgi_word;
        logic              last_word;
    } result_t;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] idx;
        logic [AFF_W-1:0]     data;
    } cfg_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // cluster holds affinity bits 39..8; bits 31..24 of the affinity are not emitted
    function automatic logic [WORD_W-1:0] make_word(
        input logic [CLUSTER_W-1:0] cluster,
        input logic [SGI_W-1:0]     sgi,
        input logic [TLIST_W-1:0]   tlist
    );
        make_word = {cluster[31:24], 8'h00, cluster[15:8], 4'h0, sgi,
                     cluster[7:0], tlist};
    endfunction

endpackage

/* hw/rtl/sgi_target_list_generator_unit.sv */
// sgi_target_list_generator_unit: top level, walks the target cores one a
// cycle and packs runs of same-cluster cores into sgi words
// depends on stgu_pkg and stgu_aff_regs
//
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------
// request   | start, busy            | req (sgi_id, target_mask)
// result    | result_valid (strobe)  | result (sgi_word, last_word)
// config    | cfg_we                 | cfg_index, cfg_wdata
//
// busy is high from the accepting edge while the walk sequencer steps through the
// cores, one core per cycle, and then in the flush state that closes the open run
// the final word beat comes in the same cycle as busy falls, and a new request is
// taken only while busy is low; words leave one per cycle at most
// the receiver cannot stall, so nothing ever holds the walk back
// reset (rst_n, async low) loads core n affinity with n and idles the sequencer
module sgi_target_list_generator_unit #(
    parameter int CORE_COUNT = stgu_pkg::DEF_CORE_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  stgu_pkg::req_t                req,
    output logic                          result_valid,
    output stgu_pkg::result_t             result,
    input  logic                          cfg_we,
    input  logic [stgu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stgu_pkg::AFF_W-1:0]    cfg_wdata
);
    import stgu_pkg::*;

    localparam int IDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CORE_COUNT-1:0] mask_reg, mask_next;
    logic [SGI_W-1:0]      sgi_reg, sgi_next;
    logic                  open_reg, open_next;
    logic [CLUSTER_W-1:0]  cluster_reg, cluster_next;
    logic [TLIST_W-1:0]    tlist_reg, tlist_next;
    logic                  valid_reg, valid_next;
    result_t               out_reg, out_next;

    cfg_wr_t               cfg;
    logic [AFF_W-1:0]      aff;
    logic [CLUSTER_W-1:0]  cl;
    logic [TLIST_W-1:0]    bit_sel;

    assign cfg.en   = cfg_we;
    assign cfg.idx  = cfg_index;
    assign cfg.data = cfg_wdata;

    stgu_aff_regs #(
        .CORE_COUNT (CORE_COUNT),
        .IDX_W      (IDX_W)
    ) u_aff_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .rd_idx (idx_reg),
        .rd_aff (aff)
    );

    assign cl      = aff[AFF_W-1:8];
    assign bit_sel = TLIST_W'(1) << aff[3:0];

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        mask_next    = mask_reg;
        sgi_next     = sgi_reg;
        open_next    = open_reg;
        cluster_next = cluster_reg;
        tlist_next   = tlist_reg;
        valid_next   = 1'b0;
        out_next     = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mask_next  = req.target_mask[CORE_COUNT-1:0];
                    sgi_next   = req.sgi_id;
                    idx_next   = '0;
                    open_next  = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (mask_reg[idx_reg])
                begin
                    if (open_reg && (cl != cluster_reg))
                    begin
                        // cluster changed: close the run, another one follows
                        valid_next         = 1'b1;
                        out_next.sgi_word  = make_word(cluster_reg, sgi_reg, tlist_reg);
                        out_next.last_word = 1'b0;
                        cluster_next       = cl;
                        tlist_next         = bit_sel;
                    end
                    else if (open_reg)
                    begin
                        tlist_next = tlist_reg | bit_sel;
                    end
                    else
                    begin
                        open_next    = 1'b1;
                        cluster_next = cl;
                        tlist_next   = bit_sel;
                    end
                end
                if (idx_reg == IDX_W'(CORE_COUNT - 1))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (open_reg)
                begin
                    valid_next         = 1'b1;
                    out_next.sgi_word  = make_word(cluster_reg, sgi_reg, tlist_reg);
                    out_next.last_word = 1'b1;
                end
                open_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            open_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            open_reg  <= open_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg    <= mask_next;
        sgi_reg     <= sgi_next;
        cluster_reg <= cluster_next;
        tlist_reg   <= tlist_next;
        out_reg     <= out_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = out_reg;

endmodule

/* hw/rtl/stgu_aff_regs.sv */
// stgu_aff_regs: per-core affinity registers with a plain write port
// and one read port; depends on stgu_pkg
module stgu_aff_regs #(
    parameter int CORE_COUNT = stgu_pkg::DEF_CORE_COUNT,
    parameter int IDX_W      = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  stgu_pkg::cfg_wr_t         cfg,
    input  logic [IDX_W-1:0]          rd_idx,
    output logic [stgu_pkg::AFF_W-1:0] rd_aff
);
    import stgu_pkg::*;

    logic [AFF_W-1:0] aff_reg [CORE_COUNT];

    // indexes at or above the core count are dropped: those cores are never read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORE_COUNT; i++)
            begin
                aff_reg[i] <= AFF_W'(i);
            end
        end
        else if (cfg.en && (cfg.idx < CFG_IDX_W'(CORE_COUNT)))
        begin
            aff_reg[cfg.idx[IDX_W-1:0]] <= cfg.data;
        end
    end

    assign rd_aff = aff_reg[rd_idx];

endmodule

/* tb/tb_sgi_target_list_generator_unit.sv */
// tb_sgi_target_list_generator_unit: self-checking bench for the sgi target list generator,
// predicts every sgi word from a mirror of the affinity registers and checks each beat
// depends on stgu_pkg and sgi_target_list_generator_unit
`timescale 1ns / 1ps

module tb_sgi_target_list_generator_unit;

    import stgu_pkg::*;

    localparam int NCORES   = DEF_CORE_COUNT;
    localparam int MAX_SHOW = 10;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    req_t                 req = '0;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [AFF_W-1:0]     cfg_wdata = '0;

    // mirror of the affinity registers and the words still owed by the block
    logic [AFF_W-1:0] aff_mirror [MAX_CORES];
    logic [AFF_W-1:0] aff_plan [MAX_CORES];
    result_t          pending_words [$];
    int               err_count = 0;

    sgi_target_list_generator_unit #(
        .CORE_COUNT(NCORES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .result_valid(result_valid),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= MAX_SHOW)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic logic [WORD_W-1:0] pack_word(input logic [CLUSTER_W-1:0] cl,
                                                    input logic [SGI_W-1:0] sgi,
                                                    input logic [TLIST_W-1:0] tl);
        logic [WORD_W-1:0] w;
        w = '0;
        w[55:48] = cl[31:24];   // aff3
        w[39:32] = cl[15:8];    // aff2
        w[27:24] = sgi;
        w[23:16] = cl[7:0];     // aff1
        w[15:0]  = tl;
        return w;
    endfunction

    // walk the targeted cores, one word per run of equal cluster
    function automatic void predict_words(input req_t r);
        logic [AFF_W-1:0]     aff;
        logic [CLUSTER_W-1:0] run_cl;
        logic [TLIST_W-1:0]   tl;
        bit                   open;
        result_t              w;
        open = 1'b0;
        run_cl = '0;
        tl = '0;
        for (int c = 0; c < NCORES; c++)
        begin
            if (r.target_mask[c])
            begin
                aff = aff_mirror[c];
                if (open && aff[39:8] != run_cl)
                begin
                    w.sgi_word = pack_word(run_cl, r.sgi_id, tl);
                    w.last_word = 1'b0;
                    pending_words.push_back(w);
                    open = 1'b0;
                end
                if (!open)
                begin
                    open = 1'b1;
                    run_cl = aff[39:8];
                    tl = '0;
                end
                tl[aff[3:0]] = 1'b1;
            end
        end
        if (open)
        begin
            w.sgi_word = pack_word(run_cl, r.sgi_id, tl);
            w.last_word = 1'b1;
            pending_words.push_back(w);
        end
    endfunction

    // checks each word beat, then books new requests and register writes
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CORES; i++)
                aff_mirror[i] = AFF_W'(i);
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_words.size() == 0)
                    note_error($sformatf("unexpected word %h last %b",
                                         result.sgi_word, result.last_word));
                else
                begin
                    want = pending_words.pop_front();
                    if (result.sgi_word !== want.sgi_word)
                        note_error($sformatf("sgi_word expected %h got %h",
                                             want.sgi_word, result.sgi_word));
                    if (result.last_word !== want.last_word)
                        note_error($sformatf("last_word expected %b got %b (word %h)",
                                             want.last_word, result.last_word,
                                             want.sgi_word));
                end
            end
            if (start && !busy)
                predict_words(req);
            if (cfg_we && int'(cfg_index) < MAX_CORES)
                aff_mirror[cfg_index] = cfg_wdata;
        end
    end

    task automatic issue_request(input logic [SGI_W-1:0] sgi, input logic [MASK_W-1:0] mask,
                                 input bit gaps);
        int bursts;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            bursts = $urandom_range(1, 3);
            for (int b = 0; b < bursts; b++)
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req <= '{sgi_id: sgi, target_mask: mask};
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // let every owed word arrive and the walk finish, empty masks included
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (NCORES + 3) @(posedge clk);
    endtask

    // all eight registers, then one write to an index past the last register
    task automatic write_aff_plan();
        for (int i = 0; i < MAX_CORES; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= aff_plan[i];
            @(posedge clk);
        end
        cfg_index <= CFG_IDX_W'($urandom_range(MAX_CORES, 2**CFG_IDX_W - 1));
        cfg_wdata <= {8'($urandom()), 32'($urandom())};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_affinity();
        issue_request(4'h0, 8'h0F, 1'b1);
        issue_request(4'hF, 8'h00, 1'b1);
        // mask bits past the core count do nothing
        issue_request(4'hA, 8'hF0, 1'b1);
        issue_request(4'h5, 8'h09, 1'b1);
        issue_request(4'h1, 8'hFF, 1'b1);
    endtask

    task automatic test_cluster_runs();
        wait_idle();
        aff_plan[0] = 40'h00_0000_0103;
        aff_plan[1] = 40'h00_0002_0005;
        aff_plan[2] = 40'h00_0000_01F3;   // same cluster and nibble as core 0
        aff_plan[3] = 40'h00_0000_0107;
        for (int i = 4; i < MAX_CORES; i++)
            aff_plan[i] = 40'h12_3456_7800 | AFF_W'(i);
        write_aff_plan();
        issue_request(4'h3, 8'h0F, 1'b1);
        issue_request(4'h7, 8'h05, 1'b1);
        issue_request(4'h8, 8'h0D, 1'b1);
        issue_request(4'hC, 8'h02, 1'b1);
        issue_request(4'h0, 8'h03, 1'b1);
    endtask

    task automatic test_extreme_affinity();
        wait_idle();
        aff_plan[0] = '1;
        aff_plan[1] = '0;
        aff_plan[2] = 40'h00_FF00_0000;   // differs from core 1 only in unemitted bits
        aff_plan[3] = '1;
        aff_plan[4] = '1;
        aff_plan[5] = '0;
        aff_plan[6] = 40'hAA_5555_AAAA;
        aff_plan[7] = 40'h55_AAAA_5555;
        write_aff_plan();
        issue_request(4'hF, 8'h0F, 1'b1);
        issue_request(4'h0, 8'h06, 1'b1);
        issue_request(4'h9, 8'h09, 1'b1);
        issue_request(4'hF, 8'hFF, 1'b1);
        issue_request(4'h6, 8'h0A, 1'b1);
    endtask

    task automatic test_random_requests();
        logic [CLUSTER_W-1:0] cluster_pool [3];
        int                   nclusters;
        bit                   gaps;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            nclusters = (phase == 0) ? 1 : $urandom_range(2, 3);
            for (int k = 0; k < 3; k++)
                cluster_pool[k] = $urandom();
            for (int i = 0; i < MAX_CORES; i++)
                aff_plan[i] = {cluster_pool[$urandom_range(0, nclusters - 1)], 8'($urandom())};
            // now and then a core outside every shared cluster
            if ($urandom_range(0, 1) == 0)
                aff_plan[$urandom_range(0, NCORES - 1)] = {8'($urandom()), 32'($urandom())};
            write_aff_plan();
            gaps = (phase < 3);
            for (int n = 0; n < 40; n++)
            begin
                if (n == 20)
                    wait_idle();
                issue_request(SGI_W'($urandom_range(0, 15)), MASK_W'($urandom_range(0, 255)),
                              gaps);
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_affinity();
        test_cluster_runs();
        test_extreme_affinity();
        test_random_requests();

        wait_idle();
        if (pending_words.size() != 0)
            note_error($sformatf("%0d words never arrived", pending_words.size()));
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
